>>> design/chinese_remainder_solver_macros.svh
// Assertion macros for the CRT solver block.
// Used by the top level; relies on clk and arst_n in scope.
`ifndef CHINESE_REMAINDER_SOLVER_MACROS_SVH
`define CHINESE_REMAINDER_SOLVER_MACROS_SVH

// same-cycle implication
`define CRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/crs_pkg.sv
// Shared types and constants of the CRT solver.
// No dependencies.
package crs_pkg;

	localparam int MAX_CONGRUENCES = 8;
	localparam int MODULUS_BITS    = 8;
	localparam int STORE_DEPTH     = 8;
	localparam int IDX_W           = 3;
	localparam int CNT_W           = 4;
	localparam int DIV_CNT_W       = 6;
	localparam logic [7:0] MOD_MASK = 8'((1 << MODULUS_BITS) - 1);

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_INV   = 2'd1,
		STAT_TOO_MANY = 2'd2
	} crs_status_t;

	typedef enum logic [1:0] {
		DIV_BIG,
		DIV_COF,
		DIV_RK
	} crs_div_src_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_INIT,
		ST_ENTRY,
		ST_W_COF,
		ST_S_COFR,
		ST_W_COFR,
		ST_SEARCH,
		ST_S_K,
		ST_W_K,
		ST_MUL,
		ST_ROOM,
		ST_ADD,
		ST_OUT
	} crs_state_t;

	typedef struct packed {
		logic         load;
		logic         init;
		logic         start_div;
		crs_div_src_t div_src;
		logic         lat_cof;
		logic         lat_cofr;
		logic         search_step;
		logic         lat_inv;
		logic         lat_k;
		logic         mul;
		logic         room;
		logic         add;
		logic         set_status;
		crs_status_t  status;
		logic         emit;
	} crs_cmd_t;

	typedef struct packed {
		logic ovf;
		logic idx_end;
		logic mod_small;
		logic div_done;
		logic t_is_one;
		logic j_last;
		logic out_busy;
	} crs_stat_t;

endpackage

>>> design/crs_div.sv
// Bit-serial restoring divider: 64-bit dividend by 8-bit divisor.
// One quotient bit per cycle; uses crs_pkg.
module crs_div import crs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [63:0] quotient,
	output logic [7:0]  remainder
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [63:0]          quo_q;
	logic [7:0]           rem_q;
	logic [7:0]           d_q;
	logic [8:0]           trial;
	logic                 ge;

	assign trial = {rem_q, quo_q[63]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? 8'(trial - {1'b0, d_q}) : trial[7:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> design/crs_dp.sv
// Datapath: congruence store, running product, divider, inverse search,
// accumulator and output word register. Uses crs_pkg and crs_div.
module crs_dp import crs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  crs_cmd_t     cmd,
	output crs_stat_t    stat,
	input  logic [15:0]  in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [127:0] out_data,
	output logic [1:0]   out_user
);

	logic [7:0]       res_mem [STORE_DEPTH];
	logic [7:0]       mod_mem [STORE_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [63:0]      product_q;
	logic             ovf_q;
	logic [63:0]      cof_q;
	logic [7:0]       cofr_q;
	logic [7:0]       j_q;
	logic [7:0]       t_q;
	logic [7:0]       inv_q;
	logic [7:0]       k_q;
	logic [63:0]      term_q;
	logic [63:0]      room_q;
	logic [63:0]      acc_q;
	crs_status_t      status_q;
	logic             out_valid_q;
	logic [63:0]      sol_q;
	logic [63:0]      big_q;
	logic [1:0]       ostat_q;

	logic [7:0]  r_in;
	logic [7:0]  m_in;
	logic [7:0]  m_mul;
	logic [7:0]  n;
	logic [7:0]  r;
	logic [15:0] rk;
	logic [8:0]  t_sum;
	logic [7:0]  t_next;
	logic [63:0] div_a;
	logic        div_done;
	logic [63:0] div_q;
	logic [7:0]  div_r;

	assign r_in  = in_data[7:0];
	assign m_in  = in_data[15:8] & MOD_MASK;
	assign m_mul = (m_in == '0) ? 8'd1 : m_in;
	assign n     = mod_mem[idx_q[IDX_W-1:0]];
	assign r     = res_mem[idx_q[IDX_W-1:0]];
	assign rk    = r * inv_q;
	assign t_sum = {1'b0, t_q} + {1'b0, cofr_q};
	assign t_next = (t_sum >= {1'b0, n}) ? 8'(t_sum - {1'b0, n}) : t_sum[7:0];

	always_comb begin
		case (cmd.div_src)
			DIV_BIG: div_a = product_q;
			DIV_COF: div_a = cof_q;
			DIV_RK:  div_a = {48'd0, rk};
			default: div_a = product_q;
		endcase
	end

	crs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start_div),
		.dividend  (div_a),
		.divisor   (n),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// set bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			product_q <= 64'd1;
			ovf_q     <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (cmd.load) begin
				if (count_q < CNT_W'(MAX_CONGRUENCES)) begin
					count_q   <= count_q + 1'b1;
					product_q <= 64'(product_q * m_mul);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.init)
				idx_q <= '0;
			else if (cmd.add)
				idx_q <= idx_q + 1'b1;
			if (cmd.emit) begin
				count_q   <= '0;
				product_q <= 64'd1;
				ovf_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && count_q < CNT_W'(MAX_CONGRUENCES)) begin
			res_mem[count_q[IDX_W-1:0]] <= r_in;
			mod_mem[count_q[IDX_W-1:0]] <= m_in;
		end
		if (cmd.init)
			acc_q <= '0;
		if (cmd.lat_cof)
			cof_q <= div_q;
		if (cmd.lat_cofr) begin
			cofr_q <= div_r;
			t_q    <= div_r;
			j_q    <= 8'd1;
		end
		if (cmd.search_step) begin
			t_q <= t_next;
			j_q <= j_q + 1'b1;
		end
		if (cmd.lat_inv)
			inv_q <= j_q;
		if (cmd.lat_k)
			k_q <= div_r;
		if (cmd.mul)
			term_q <= 64'(cof_q * k_q);
		if (cmd.room)
			room_q <= product_q - term_q;
		if (cmd.add)
			acc_q <= (acc_q >= room_q) ? acc_q - room_q : acc_q + term_q;
		if (cmd.set_status)
			status_q <= cmd.status;
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sol_q   <= (status_q == STAT_OK) ? acc_q : 64'd0;
			big_q   <= product_q;
			ostat_q <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {big_q, sol_q};
	assign out_user  = ostat_q;

	assign stat.ovf       = ovf_q;
	assign stat.idx_end   = idx_q == count_q;
	assign stat.mod_small = n < 8'd2;
	assign stat.div_done  = div_done;
	assign stat.t_is_one  = t_q == 8'd1;
	assign stat.j_last    = j_q == 8'(n - 8'd1);
	assign stat.out_busy  = out_valid_q && !out_ready;

endmodule

>>> design/crs_ctrl.sv
// Controller state machine of the CRT solver.
// Drives crs_dp through crs_cmd_t; uses crs_pkg.
module crs_ctrl import crs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	input  crs_stat_t stat,
	output crs_cmd_t  cmd
);

	crs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:   if (in_valid && in_last) state_d = ST_INIT;
			ST_INIT:   state_d = stat.ovf ? ST_OUT : ST_ENTRY;
			ST_ENTRY: begin
				if (stat.idx_end || stat.mod_small)
					state_d = ST_OUT;
				else
					state_d = ST_W_COF;
			end
			ST_W_COF:  if (stat.div_done) state_d = ST_S_COFR;
			ST_S_COFR: state_d = ST_W_COFR;
			ST_W_COFR: if (stat.div_done) state_d = ST_SEARCH;
			ST_SEARCH: begin
				if (stat.t_is_one)
					state_d = ST_S_K;
				else if (stat.j_last)
					state_d = ST_OUT;
			end
			ST_S_K:    state_d = ST_W_K;
			ST_W_K:    if (stat.div_done) state_d = ST_MUL;
			ST_MUL:    state_d = ST_ROOM;
			ST_ROOM:   state_d = ST_ADD;
			ST_ADD:    state_d = ST_ENTRY;
			ST_OUT:    if (!stat.out_busy) state_d = ST_LOAD;
			default:   state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.div_src = DIV_BIG;
		cmd.status  = STAT_OK;
		in_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_INIT: begin
				cmd.init       = 1'b1;
				cmd.set_status = 1'b1;
				cmd.status     = stat.ovf ? STAT_TOO_MANY : STAT_OK;
			end
			ST_ENTRY: begin
				if (stat.idx_end) begin
					cmd.set_status = 1'b1;
					cmd.status     = STAT_OK;
				end else if (stat.mod_small) begin
					cmd.set_status = 1'b1;
					cmd.status     = STAT_NO_INV;
				end else begin
					cmd.start_div = 1'b1;
					cmd.div_src   = DIV_BIG;
				end
			end
			ST_W_COF:  cmd.lat_cof = stat.div_done;
			ST_S_COFR: begin
				cmd.start_div = 1'b1;
				cmd.div_src   = DIV_COF;
			end
			ST_W_COFR: cmd.lat_cofr = stat.div_done;
			ST_SEARCH: begin
				if (stat.t_is_one) begin
					cmd.lat_inv = 1'b1;
				end else if (stat.j_last) begin
					cmd.set_status = 1'b1;
					cmd.status     = STAT_NO_INV;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			ST_S_K: begin
				cmd.start_div = 1'b1;
				cmd.div_src   = DIV_RK;
			end
			ST_W_K:    cmd.lat_k = stat.div_done;
			ST_MUL:    cmd.mul = 1'b1;
			ST_ROOM:   cmd.room = 1'b1;
			ST_ADD:    cmd.add = 1'b1;
			ST_OUT:    cmd.emit = !stat.out_busy;
			default:   cmd = '0;
		endcase
	end

endmodule

>>> design/chinese_remainder_solver.sv
// Top level of the CRT solver: controller plus datapath.
// Uses crs_pkg, crs_ctrl, crs_dp and the assertion macro header.
//
//  channel  dir  word contents
//  s_axis   in   tdata[7:0] residue, [15:8] modulus; tlast = last of set
//  m_axis   out  tdata[63:0] solution, [127:64] combined modulus; tuser status
//
// Congruences load at one word per cycle. After the last word the solve takes
// each congruence in turn through three runs of the bit-serial divider, a
// linear inverse search and the multiply, room and add steps; the result word
// may also wait on an output stall.
// Input is held off (tready low) during the solve; a pending result word does not
// block loading. Reset clears the set; stores need no clearing.
`include "chinese_remainder_solver_macros.svh"
module chinese_remainder_solver import crs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [15:0]  s_axis_tdata,   // residue, modulus
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,   // solution, combined_modulus
	output logic [1:0]   m_axis_tuser    // status
);

	crs_cmd_t  cmd;
	crs_stat_t stat;

	crs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	crs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

	`CRS_ASSERT_NOW(a_err_zero_sol, m_axis_tvalid && m_axis_tuser != STAT_OK, m_axis_tdata[63:0] == 64'd0, "solution not zero on error")
	`CRS_ASSERT_NOW(a_mod_nonzero, m_axis_tvalid, m_axis_tdata[127:64] != 64'd0, "combined modulus is zero")
	`CRS_ASSERT_NEXT(a_solve_blocks, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input taken during solve")

endmodule

>>> tb/chinese_remainder_solver_test.sv
// Self-checking bench for chinese_remainder_solver: directed and random congruence sets.
// Depends on crs_pkg and the solver RTL; predicts each solution in the scoreboard class.
module chinese_remainder_solver_test import crs_pkg::*;;

	class crt_scoreboard;
		logic [7:0]  res_q[$];
		logic [7:0]  mod_q[$];
		logic [63:0] product;
		bit          overflow;
		logic [63:0] sol_q[$];
		logic [63:0] prod_q[$];
		crs_status_t stat_q[$];
		int          errors;
		int          results;
		int          status_seen[3];

		function new();
			product = 64'd1;
			overflow = 0;
			errors = 0;
			results = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		task report(string what, logic [127:0] got, logic [127:0] want);
			errors++;
			$display("MISMATCH %s: got %0h want %0h", what, got, want);
		endtask

		// solve the stored set; returns status, solution via sol
		function crs_status_t solve_set(output logic [63:0] sol);
			logic [63:0] n, cof, cofr, inv, k, acc, term;
			sol = 64'd0;
			acc = 64'd0;
			if (overflow) return STAT_TOO_MANY;
			foreach (mod_q[i]) if (mod_q[i] < 8'd2) return STAT_NO_INV;
			foreach (mod_q[i]) begin
				n = {56'd0, mod_q[i]};
				cof = product / n;
				cofr = cof % n;
				inv = 64'd0;
				for (int j = 1; j < n; j++) begin
					if ((cofr * j) % n == 64'd1) begin
						inv = j;
						break;
					end
				end
				if (inv == 64'd0) return STAT_NO_INV;
				k = ({56'd0, res_q[i]} * inv) % n;
				term = (cof * k) % product;
				acc = (acc >= product - term) ? acc - (product - term) : acc + term;
			end
			sol = acc;
			return STAT_OK;
		endfunction

		function void note_congruence(logic [7:0] r, logic [7:0] m, logic lst);
			logic [63:0] s;
			crs_status_t st;
			m = m & MOD_MASK;
			if (mod_q.size() < MAX_CONGRUENCES) begin
				res_q = {res_q, r};
				mod_q = {mod_q, m};
				product = product * ((m == 8'd0) ? 64'd1 : {56'd0, m});
			end else
				overflow = 1;
			if (!lst) return;
			st = solve_set(s);
			sol_q = {sol_q, s};
			prod_q = {prod_q, product};
			stat_q = {stat_q, st};
			res_q.delete();
			mod_q.delete();
			product = 64'd1;
			overflow = 0;
		endfunction

		task check_word(logic [127:0] d, logic [1:0] u);
			if (sol_q.size() == 0) begin
				report("unexpected word", d, 0);
				return;
			end
			results++;
			status_seen[stat_q[0]]++;
			if (d[63:0] !== sol_q[0]) report("solution", d[63:0], sol_q[0]);
			if (d[127:64] !== prod_q[0]) report("combined_modulus", d[127:64], prod_q[0]);
			if (u !== stat_q[0]) report("status", u, stat_q[0]);
			void'(sol_q.pop_front());
			void'(prod_q.pop_front());
			void'(stat_q.pop_front());
		endtask
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [15:0]  s_axis_tdata = 0;
	logic         s_axis_tlast = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [127:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	crt_scoreboard sb = new();
	int idle_cycles = 0;
	int items = 0;
	int sink_wait = 0;
	int sink_gap;

	chinese_remainder_solver dut (.*);

	always #2 clk = ~clk;

	// sink: draws a random stall, possibly none, after each word
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_word(m_axis_tdata, m_axis_tuser);
				sink_gap = $urandom_range(0, 18);
				sink_wait <= sink_gap;
				m_axis_tready <= (sink_gap == 0);
			end else if (sink_wait > 1)
				sink_wait <= sink_wait - 1;
			else begin
				sink_wait <= 0;
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_word(logic [7:0] r, logic [7:0] m, logic lst, bit nogap);
		int gap;
		gap = nogap ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {m, r};
		s_axis_tlast <= lst;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_congruence(r, m, lst);
		items++;
	endtask

	function automatic logic [7:0] rand_prime();
		logic [7:0] p[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
			53, 59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 127, 131, 251};
		return p[$urandom_range(0, p.size() - 1)];
	endfunction

	// set of pairwise coprime moduli (distinct primes or prime powers)
	task automatic send_good_set(int cnt, bit fast);
		logic [7:0] used[$];
		logic [7:0] m;
		bit dup;
		for (int i = 0; i < cnt; i++) begin
			do begin
				m = rand_prime();
				dup = 0;
				foreach (used[j]) if (used[j] == m) dup = 1;
			end while (dup);
			used = {used, m};
			if (m < 16 && $urandom_range(0, 2) == 0) m = m * m;
			send_word(8'($urandom), m, i == cnt - 1, fast && $urandom_range(0, 1));
		end
	endtask

	task automatic send_random_set(int cnt);
		for (int i = 0; i < cnt; i++)
			send_word(8'($urandom), 8'($urandom), i == cnt - 1, 0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes and each special case
		send_word(8'd255, 8'd255, 1, 0);              // single congruence
		send_word(8'd0, 8'd2, 0, 1);
		send_word(8'd255, 8'd3, 1, 1);                // residue above modulus
		send_word(8'd1, 8'd0, 0, 0);                  // zero modulus
		send_word(8'd1, 8'd5, 1, 0);
		send_word(8'd1, 8'd1, 1, 0);                  // modulus one
		send_word(8'd4, 8'd6, 0, 0);                  // not coprime
		send_word(8'd3, 8'd4, 1, 0);
		for (int i = 0; i < 9; i++)                   // one too many
			send_word(8'hAA, 8'd3, i == 8, 1);
		send_word(8'h55, 8'd128, 0, 0);
		send_word(8'h7F, 8'd255, 0, 1);
		send_word(8'h80, 8'd253, 1, 0);
		send_good_set(8, 1);                          // full set, large product
		// random: mostly well-formed sets, some noise
		while (items < 1450) begin
			case ($urandom_range(0, 9))
				0, 1: send_random_set($urandom_range(1, 4));
				2: send_random_set($urandom_range(8, 11));
				default: send_good_set($urandom_range(1, 8), $urandom_range(0, 1));
			endcase
		end
		s_axis_tvalid <= 0;
		wait (sb.sol_q.size() == 0);
		repeat (400) @(posedge clk);
		$display("Sent %0d congruences, checked %0d solutions", items, sb.results);
		$display("status ok/no-inverse/too-many: %0d/%0d/%0d",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
		if (sb.errors == 0 && sb.sol_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> chinese_remainder_solver.f
+incdir+design
design/crs_pkg.sv
design/crs_div.sv
design/crs_dp.sv
design/crs_ctrl.sv
design/chinese_remainder_solver.sv
tb/chinese_remainder_solver_test.sv
